### rtl/fir_filter_127_tap_top_macros.svh
// ----------------------------------------------------------------------------
// fir filter assertion macros
// concurrent checks clocked on clock and disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_127_TAP_TOP_MACROS_SVH
`define FIR_FILTER_127_TAP_TOP_MACROS_SVH
`ifndef SYNTH
// property that holds at every edge outside reset
`define FIR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// antecedent implies consequent in the following cycle
`define FIR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FIR_ASSERT(lbl, prop, msg)
`define FIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/fir127_pkg.sv
// ----------------------------------------------------------------------------
// fir127_pkg
// sizes, coefficient rom contents and shared types of the fir filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fir127_pkg;

   localparam int TAPS         = 127;
   localparam int COEF_WIDTH   = 16;
   localparam int SAMPLE_WIDTH = 16;

   localparam int PTR_WIDTH  = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int TAP_WIDTH  = $clog2(TAPS + 1);
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + $clog2(TAPS + 1);

   localparam int TABLE_LEN = 127;
   localparam longint MICRO = 1000000;

   // coefficients in millionths
   localparam int COEF_MICRO [TABLE_LEN] = '{
      345, 300, 243, 171, 85,
      -18, -137, -271, -416, -568,
      -719, -860, -980, -1066, -1105,
      -1083, -990, -815, -554, -205,
      225, 725, 1278, 1859, 2435,
      2973, 3432, 3773, 3954, 3940,
      3701, 3214, 2468, 1467, 228,
      -1217, -2817, -4509, -6212, -7838,
      -9287, -10454, -11237, -11536, -11259,
      -10331, -8694, -6312, -3177, 695,
      5255, 10427, 16109, 22172, 28468,
      34831, 41086, 47056, 52564, 57444,
      61546, 64741, 66930, 68042, 68042,
      66930, 64741, 61546, 57444, 52564,
      47056, 41086, 34831, 28468, 22172,
      16109, 10427, 5255, 695, -3177,
      -6312, -8694, -10331, -11259, -11536,
      -11237, -10454, -9287, -7838, -6212,
      -4509, -2817, -1217, 228, 1467,
      2468, 3214, 3701, 3940, 3954,
      3773, 3432, 2973, 2435, 1859,
      1278, 725, 225, -205, -554,
      -815, -990, -1083, -1105, -1066,
      -980, -860, -719, -568, -416,
      -271, -137, -18, 85, 171,
      0, 0
   };

   typedef logic signed [COEF_WIDTH-1:0] coef_table_type [TAPS];

   // round half away from zero to COEF_WIDTH-1 fraction bits
   function automatic coef_table_type build_coef_table();
      coef_table_type tbl;
      longint mag;
      longint q;
      for (int i = 0; i < TAPS; i++) begin
         if (i >= TABLE_LEN) begin
            tbl[i] = '0;
         end else begin
            mag = (COEF_MICRO[i] < 0) ? -longint'(COEF_MICRO[i]) : longint'(COEF_MICRO[i]);
            q = ((mag << (COEF_WIDTH - 1)) + MICRO / 2) / MICRO;
            tbl[i] = (COEF_MICRO[i] < 0) ? COEF_WIDTH'(-q) : COEF_WIDTH'(q);
         end
      end
      return tbl;
   endfunction

   localparam coef_table_type COEF_TABLE = build_coef_table();

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic tap_valid;
   } mac_ctrl_type;

endpackage

### rtl/fir127_mac.sv
// ----------------------------------------------------------------------------
// fir127_mac
// shared multiply-accumulate with q1.15 rounding and saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir127_mac
   import fir127_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  mac_ctrl_type                   ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] data,
   input  logic signed [COEF_WIDTH-1:0]   coef,
   output logic                           busy,
   output logic signed [SAMPLE_WIDTH-1:0] result
);

   localparam int ROUND_SHIFT = COEF_WIDTH - 1;
   localparam logic signed [ACC_WIDTH:0] ROUND_HALF = (ACC_WIDTH + 1)'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [ACC_WIDTH:0] SAT_MAX = (ACC_WIDTH + 1)'(2 ** (SAMPLE_WIDTH - 1) - 1);
   localparam logic signed [ACC_WIDTH:0] SAT_MIN = -SAT_MAX - (ACC_WIDTH + 1)'(1);

   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;
   logic                         prod_vld_ff;
   logic                         prod_vld_in;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic signed [ACC_WIDTH-1:0]  acc_in;
   logic signed [ACC_WIDTH:0]    rnd;
   logic signed [ACC_WIDTH:0]    quo;

   assign prod_in     = data * coef;
   assign prod_vld_in = ctrl.tap_valid & ~ctrl.clear;

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, then clamp
   assign rnd = (ACC_WIDTH + 1)'(acc_ff) + ROUND_HALF;
   assign quo = rnd >>> ROUND_SHIFT;

   always_comb begin
      if (quo > SAT_MAX) begin
         result = SAT_MAX[SAMPLE_WIDTH-1:0];
      end else if (quo < SAT_MIN) begin
         result = SAT_MIN[SAMPLE_WIDTH-1:0];
      end else begin
         result = quo[SAMPLE_WIDTH-1:0];
      end
   end

   assign busy = prod_vld_ff;

endmodule

### rtl/fir_filter_127_tap_top.sv
// ----------------------------------------------------------------------------
// fir_filter_127_tap_top: 127-tap fir low-pass over a circular delay memory
// one item at a time; each is processed by one shared multiply-accumulate reading
// one delay memory entry per cycle, then the two-stage product pipeline drain and the
// result hand-off; a result not yet taken while rsp_ready is low stalls the next item
// in the done state
// reset clears pointer, fill count and control; no clearing pass is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fir_filter_127_tap_top_macros.svh"

module fir_filter_127_tap_top
   import fir127_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_filtered
);

   logic signed [SAMPLE_WIDTH-1:0] delay_mem [TAPS];

   state_type state_ff;
   state_type state_in;

   logic [PTR_WIDTH-1:0]           ptr_ff;
   logic [PTR_WIDTH-1:0]           ptr_in;
   logic [TAP_WIDTH-1:0]           fill_ff;
   logic [TAP_WIDTH-1:0]           fill_in;
   logic [TAP_WIDTH-1:0]           tap_ff;
   logic [TAP_WIDTH-1:0]           tap_in;
   logic [PTR_WIDTH-1:0]           tap_idx;
   logic [PTR_WIDTH:0]             addr_wide;
   logic [PTR_WIDTH-1:0]           rd_addr;
   logic signed [SAMPLE_WIDTH-1:0] rd_data_ff;
   logic                           ent_ok_ff;
   logic signed [COEF_WIDTH-1:0]   coef_ff;
   logic                           rd_vld_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_ff;

   logic accept;
   logic issue;
   logic last_tap;
   logic finish;

   mac_ctrl_type                   mac_ctrl;
   logic                           mac_busy;
   logic signed [SAMPLE_WIDTH-1:0] mac_result;
   logic signed [SAMPLE_WIDTH-1:0] mac_data;

   assign tap_idx  = tap_ff[PTR_WIDTH-1:0];
   assign last_tap = (tap_ff == TAP_WIDTH'(TAPS - 1));

   // address of the sample tap_idx places back from the newest
   always_comb begin
      if (tap_idx <= ptr_ff) begin
         addr_wide = {1'b0, ptr_ff} - {1'b0, tap_idx};
      end else begin
         addr_wide = {1'b0, ptr_ff} + (PTR_WIDTH + 1)'(TAPS) - {1'b0, tap_idx};
      end
   end
   assign rd_addr = addr_wide[PTR_WIDTH-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !mac_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_RUN:   issue     = 1'b1;
         ST_DRAIN: ;
         ST_DONE:  finish    = !rsp_valid_ff || rsp_ready;
         default:  ;
      endcase
   end

   assign accept = req_valid & req_ready;

   always_comb begin
      ptr_in  = ptr_ff;
      fill_in = fill_ff;
      tap_in  = tap_ff;
      if (accept) begin
         tap_in = '0;
         if (fill_ff != TAP_WIDTH'(TAPS)) begin
            fill_in = fill_ff + TAP_WIDTH'(1);
         end
      end else if (issue) begin
         tap_in = tap_ff + TAP_WIDTH'(1);
      end
      if (finish) begin
         ptr_in = (ptr_ff == PTR_WIDTH'(TAPS - 1)) ? '0 : ptr_ff + PTR_WIDTH'(1);
      end
   end

   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         tap_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         tap_ff       <= tap_in;
         rd_vld_ff    <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // delay memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (accept) begin
         delay_mem[ptr_ff] <= req_sample;
      end
      if (issue) begin
         rd_data_ff <= delay_mem[rd_addr];
      end
   end

   // entries past the fill count were never written and read as zero
   always_ff @(posedge clock) begin
      if (issue) begin
         ent_ok_ff <= TAP_WIDTH'(rd_addr) < fill_ff;
         coef_ff   <= COEF_TABLE[tap_idx];
      end
      if (finish) begin
         rsp_filtered_ff <= mac_result;
      end
   end

   assign mac_data           = ent_ok_ff ? rd_data_ff : '0;
   assign mac_ctrl.clear     = accept;
   assign mac_ctrl.tap_valid = rd_vld_ff;

   fir127_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .data   (mac_data),
      .coef   (coef_ff),
      .busy   (mac_busy),
      .result (mac_result)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   `FIR_ASSERT(a_accept_quiet, accept |-> !(rd_vld_ff || mac_busy), "item accepted mid run")
   `FIR_ASSERT(a_fill_range, fill_ff <= TAP_WIDTH'(TAPS), "fill count beyond tap count")
   `FIR_ASSERT_NEXT(a_done_taps, (state_ff == ST_DRAIN) && (state_in == ST_DONE), tap_ff == TAP_WIDTH'(TAPS), "result formed before all taps")
   `FIR_ASSERT_NEXT(a_finish_rsp, finish, rsp_valid_ff && (state_ff == ST_IDLE), "finished item not presented")

endmodule
